### rtl/slb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slb_pkg;

  localparam int unsigned PERIOD_W      = 14;
  localparam int unsigned FLASH_W       = 16;
  localparam int unsigned LEVEL_W       = 8;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 14;
  localparam int unsigned PROD_W        = 22;

  localparam logic [PERIOD_W-1:0] PERIOD_MAX_MS   = 14'd10000;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN_USED = 14'd50;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET    = 14'd1000;
  localparam logic [PERIOD_W-1:0] EDGE_MS         = 14'd10;
  localparam logic [LEVEL_W-1:0]  FLASH_RED       = 8'd48;
  localparam logic [LEVEL_W-1:0]  DUTY_OFF        = 8'd0;
  localparam logic [LEVEL_W-1:0]  DUTY_SOLID      = 8'd255;
  localparam logic [PROD_W-1:0]   ROUND_HALF      = 22'd127;

  typedef enum logic [CFG_IDX_W-1:0] {
    IDX_RED    = 3'd0,
    IDX_GREEN  = 3'd1,
    IDX_BLUE   = 3'd2,
    IDX_BRIGHT = 3'd3,
    IDX_DUTY   = 3'd4,
    IDX_PERIOD = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic                settled;
    logic [LEVEL_W-1:0]  duty;
    logic [PERIOD_W-1:0] period;
    logic [PERIOD_W-1:0] on_time;
    logic [LEVEL_W-1:0]  red;
    logic [LEVEL_W-1:0]  green;
    logic [LEVEL_W-1:0]  blue;
  } cfg_t;

  // floor(y / 255) for y below 2^22: shift-add reciprocal, then one correction
  function automatic logic [PROD_W-1:0] div255(input logic [PROD_W-1:0] y);
    logic [45:0]       t;
    logic [PROD_W-1:0] q;
    logic [PROD_W:0]   r;
    t = ({24'b0, y} << 16) + ({24'b0, y} << 8) + {24'b0, y};
    q = t[45:24];
    r = {1'b0, y} - {q[14:0], 8'b0} + {1'b0, q};
    if (r >= 23'd255) begin
      q = q + 22'd1;
    end
    return q;
  endfunction

endpackage

`default_nettype wire

### rtl/status_led_blinker_top.sv
// Status LED blink controller: one input transaction per millisecond tick,
// one RGB result per tick. An accepted tick passes the input register, then
// the result register; a new tick can be accepted every cycle while the
// output is not stalled. Blink on-time and brightness-scaled colors are
// derived from the configuration registers through a two-stage pipeline,
// so the input side also stalls after reset and after each config write.
`timescale 1ns / 1ps
`default_nettype none

module status_led_blinker_top
  import slb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic                  flash_request_i,
  input  wire logic [FLASH_W-1:0]    flash_ms_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [LEVEL_W-1:0]         out_red_o,
  output logic [LEVEL_W-1:0]         out_green_o,
  output logic [LEVEL_W-1:0]         out_blue_o,
  output logic                       lit_o,
  output logic                       flashing_o
);

  cfg_t cfg;

  slb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  slb_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .flash_request_i (flash_request_i),
    .flash_ms_i      (flash_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .lit_o           (lit_o),
    .flashing_o      (flashing_o)
  );

endmodule

`default_nettype wire

### rtl/slb_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module slb_cfg
  import slb_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  logic [LEVEL_W-1:0]  red_q, green_q, blue_q, bright_q, duty_q;
  logic [PERIOD_W-1:0] period_q;
  logic [1:0]          settle_q, settle_d;
  logic                wr;

  logic [PERIOD_W-1:0] per_c;
  logic [PERIOD_W-1:0] per_a_q;
  logic [PROD_W-1:0]   prod_q;
  logic [15:0]         red_p_q, green_p_q, blue_p_q;

  logic [PERIOD_W-1:0] on_raw, on_lo, on_cl;
  logic [PROD_W-1:0]   on_div, red_div, green_div, blue_div;
  logic [PERIOD_W-1:0] per_b_q, on_q;
  logic [LEVEL_W-1:0]  red_s_q, green_s_q, blue_s_q;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_q    <= '0;
      green_q  <= '0;
      blue_q   <= '0;
      bright_q <= '0;
      duty_q   <= '0;
      period_q <= PERIOD_RESET;
    end else if (wr) begin
      case (cfg_idx_e'(cfg_index_i))
        IDX_RED:    red_q    <= cfg_data_i[LEVEL_W-1:0];
        IDX_GREEN:  green_q  <= cfg_data_i[LEVEL_W-1:0];
        IDX_BLUE:   blue_q   <= cfg_data_i[LEVEL_W-1:0];
        IDX_BRIGHT: bright_q <= cfg_data_i[LEVEL_W-1:0];
        IDX_DUTY:   duty_q   <= cfg_data_i[LEVEL_W-1:0];
        IDX_PERIOD: period_q <= cfg_data_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // hold the item side off until the derived values have caught up
  always_comb begin
    settle_d = settle_q;
    if (wr) begin
      settle_d = 2'd2;
    end else if (settle_q != 2'd0) begin
      settle_d = settle_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 2'd2;
    end else begin
      settle_q <= settle_d;
    end
  end

  always_comb begin
    per_c = period_q;
    if (per_c < PERIOD_MIN_USED) begin
      per_c = PERIOD_MIN_USED;
    end
    if (per_c > PERIOD_MAX_MS) begin
      per_c = PERIOD_MAX_MS;
    end
  end

  always_ff @(posedge clk_i) begin
    per_a_q   <= per_c;
    prod_q    <= PROD_W'(per_c) * PROD_W'(duty_q);
    red_p_q   <= 16'(red_q) * 16'(bright_q);
    green_p_q <= 16'(green_q) * 16'(bright_q);
    blue_p_q  <= 16'(blue_q) * 16'(bright_q);
  end

  always_comb begin
    on_div    = div255(prod_q + ROUND_HALF);
    red_div   = div255({6'b0, red_p_q} + ROUND_HALF);
    green_div = div255({6'b0, green_p_q} + ROUND_HALF);
    blue_div  = div255({6'b0, blue_p_q} + ROUND_HALF);
    on_raw    = on_div[PERIOD_W-1:0];
    on_lo     = (on_raw < EDGE_MS) ? EDGE_MS : on_raw;
    on_cl     = (on_lo > per_a_q - EDGE_MS) ? per_a_q - EDGE_MS : on_lo;
  end

  always_ff @(posedge clk_i) begin
    per_b_q   <= per_a_q;
    on_q      <= on_cl;
    red_s_q   <= red_div[LEVEL_W-1:0];
    green_s_q <= green_div[LEVEL_W-1:0];
    blue_s_q  <= blue_div[LEVEL_W-1:0];
  end

  always_comb begin
    cfg_o.settled = (settle_q == 2'd0);
    cfg_o.duty    = duty_q;
    cfg_o.period  = per_b_q;
    cfg_o.on_time = on_q;
    cfg_o.red     = red_s_q;
    cfg_o.green   = green_s_q;
    cfg_o.blue    = blue_s_q;
  end

endmodule

`default_nettype wire

### rtl/slb_core.sv
`timescale 1ns / 1ps
`default_nettype none

module slb_core
  import slb_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cfg_t               cfg_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               flash_request_i,
  input  wire logic [FLASH_W-1:0] flash_ms_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [LEVEL_W-1:0]      out_red_o,
  output logic [LEVEL_W-1:0]      out_green_o,
  output logic [LEVEL_W-1:0]      out_blue_o,
  output logic                    lit_o,
  output logic                    flashing_o
);

  logic                s1_valid_q;
  logic                s1_req_q;
  logic [FLASH_W-1:0]  s1_fms_q;
  logic                advance, accept;

  logic [FLASH_W-1:0]  flash_left_q, flash_left_d;
  logic [PERIOD_W-1:0] phase_q, phase_d;

  logic [FLASH_W-1:0]  fl;
  logic [PERIOD_W-1:0] ph, ph2, ph1;
  logic                lit_d, flashing_d;
  logic [LEVEL_W-1:0]  red_d, green_d, blue_d;

  logic                out_valid_q;
  logic [LEVEL_W-1:0]  red_q, green_q, blue_q;
  logic                lit_q, flashing_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !cfg_i.settled || (s1_valid_q && !advance);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q <= flash_request_i;
      s1_fms_q <= flash_ms_i;
    end
  end

  always_comb begin
    fl           = s1_req_q ? s1_fms_q : flash_left_q;
    ph           = s1_req_q ? '0 : phase_q;
    ph2          = (ph >= cfg_i.period) ? '0 : ph;
    ph1          = ph2 + 14'd1;
    flash_left_d = fl;
    phase_d      = '0;
    lit_d        = 1'b0;
    flashing_d   = 1'b0;
    if (fl != '0) begin
      flashing_d   = 1'b1;
      lit_d        = 1'b1;
      flash_left_d = fl - 16'd1;
    end else if (cfg_i.duty == DUTY_OFF) begin
      lit_d = 1'b0;
    end else if (cfg_i.duty == DUTY_SOLID) begin
      lit_d = 1'b1;
    end else begin
      lit_d   = ph2 < cfg_i.on_time;
      phase_d = (ph1 >= cfg_i.period) ? '0 : ph1;
    end
  end

  always_comb begin
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    if (flashing_d) begin
      red_d = FLASH_RED;
    end else if (lit_d) begin
      red_d   = cfg_i.red;
      green_d = cfg_i.green;
      blue_d  = cfg_i.blue;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      flash_left_q <= '0;
      phase_q      <= '0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        flash_left_q <= flash_left_d;
        phase_q      <= phase_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s1_valid_q) begin
      red_q      <= red_d;
      green_q    <= green_d;
      blue_q     <= blue_d;
      lit_q      <= lit_d;
      flashing_q <= flashing_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = red_q;
  assign out_green_o = green_q;
  assign out_blue_o  = blue_q;
  assign lit_o       = lit_q;
  assign flashing_o  = flashing_q;

endmodule

`default_nettype wire

### bench/tb_status_led_blinker_top.sv
`timescale 1ns / 1ps

module tb_status_led_blinker_top;
  import slb_pkg::*;

  localparam int unsigned NUM_PHASES     = 12;
  localparam int unsigned PHASE_TICKS    = 75;
  localparam int unsigned DRAIN_CYCLES   = 6;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned HOLD_PHASE     = 2;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned REPORT_LIMIT   = 10;

  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic               lit;
    logic               flashing;
  } led_drive_t;

  class led_drive_tracker;
    logic [LEVEL_W-1:0]  red_lvl;
    logic [LEVEL_W-1:0]  green_lvl;
    logic [LEVEL_W-1:0]  blue_lvl;
    logic [LEVEL_W-1:0]  bright_lvl;
    logic [LEVEL_W-1:0]  duty_lvl;
    logic [PERIOD_W-1:0] period_lvl;
    logic [FLASH_W-1:0]  flash_left;
    logic [PERIOD_W-1:0] phase_ms;
    led_drive_t          drive_q[$];
    int unsigned         mismatches;

    function new();
      red_lvl    = '0;
      green_lvl  = '0;
      blue_lvl   = '0;
      bright_lvl = '0;
      duty_lvl   = '0;
      period_lvl = PERIOD_RESET;
      flash_left = '0;
      phase_ms   = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        IDX_RED:    red_lvl    = data[LEVEL_W-1:0];
        IDX_GREEN:  green_lvl  = data[LEVEL_W-1:0];
        IDX_BLUE:   blue_lvl   = data[LEVEL_W-1:0];
        IDX_BRIGHT: bright_lvl = data[LEVEL_W-1:0];
        IDX_DUTY:   duty_lvl   = data[LEVEL_W-1:0];
        IDX_PERIOD: period_lvl = data[PERIOD_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [LEVEL_W-1:0] scaled(logic [LEVEL_W-1:0] level);
      int unsigned prod;
      prod = 32'(level) * 32'(bright_lvl) + 127;
      return LEVEL_W'(prod / 255);
    endfunction

    function void note_tick(logic req, logic [FLASH_W-1:0] fms);
      led_drive_t  drive;
      int unsigned per;
      int unsigned on_ms;
      int unsigned ph;
      drive = '0;
      if (req) begin
        flash_left = fms;
        phase_ms   = '0;
      end
      if (flash_left != 0) begin
        drive.flashing = 1'b1;
        drive.lit      = 1'b1;
        drive.red      = FLASH_RED;
        flash_left     = flash_left - 16'd1;
        phase_ms       = '0;
      end else if (duty_lvl == DUTY_OFF) begin
        phase_ms = '0;
      end else if (duty_lvl == DUTY_SOLID) begin
        drive.lit = 1'b1;
        phase_ms  = '0;
      end else begin
        per = 32'(period_lvl);
        if (per < 32'(PERIOD_MIN_USED)) per = 32'(PERIOD_MIN_USED);
        if (per > 32'(PERIOD_MAX_MS)) per = 32'(PERIOD_MAX_MS);
        on_ms = (2 * per * 32'(duty_lvl) + 255) / 510;
        if (on_ms < 32'(EDGE_MS)) on_ms = 32'(EDGE_MS);
        if (on_ms > per - 32'(EDGE_MS)) on_ms = per - 32'(EDGE_MS);
        ph = 32'(phase_ms);
        if (ph >= per) ph = 0;
        drive.lit = (ph < on_ms);
        ph = ph + 1;
        if (ph >= per) ph = 0;
        phase_ms = PERIOD_W'(ph);
      end
      if (drive.lit && !drive.flashing) begin
        drive.red   = scaled(red_lvl);
        drive.green = scaled(green_lvl);
        drive.blue  = scaled(blue_lvl);
      end
      drive_q.push_back(drive);
    endfunction

    function void check_drive(led_drive_t got);
      led_drive_t want;
      if (drive_q.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("unexpected drive: r=%0d g=%0d b=%0d lit=%0b flashing=%0b",
                   got.red, got.green, got.blue, got.lit, got.flashing);
        mismatches++;
        return;
      end
      want = drive_q.pop_front();
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.lit !== want.lit || got.flashing !== want.flashing) begin
        if (mismatches < REPORT_LIMIT) begin
          $display("drive mismatch: expected r=%0d g=%0d b=%0d lit=%0b flashing=%0b",
                   want.red, want.green, want.blue, want.lit, want.flashing);
          $display("                got      r=%0d g=%0d b=%0d lit=%0b flashing=%0b",
                   got.red, got.green, got.blue, got.lit, got.flashing);
        end
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return drive_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_valid_i     = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i     = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i      = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_stall_o;
  logic                  flash_request_i = 1'b0;
  logic [FLASH_W-1:0]    flash_ms_i      = '0;
  logic                  out_valid_o;
  logic                  out_stall_i     = 1'b0;
  logic [LEVEL_W-1:0]    out_red_o;
  logic [LEVEL_W-1:0]    out_green_o;
  logic [LEVEL_W-1:0]    out_blue_o;
  logic                  lit_o;
  logic                  flashing_o;

  led_drive_tracker tracker;
  bit               sink_quiet    = 1'b0;
  int unsigned      hold_req_cnt  = 0;
  int unsigned      hold_done_cnt = 0;
  int unsigned      idle_cycles   = 0;

  status_led_blinker_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .flash_request_i (flash_request_i),
    .flash_ms_i      (flash_ms_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_red_o       (out_red_o),
    .out_green_o     (out_green_o),
    .out_blue_o      (out_blue_o),
    .lit_o           (lit_o),
    .flashing_o      (flashing_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  initial begin : result_sink
    forever begin
      if (hold_req_cnt != hold_done_cnt) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done_cnt++;
      end else if (sink_quiet || $urandom_range(0, 99) < 55) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat (pick_gap()) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tracker.check_drive({out_red_o, out_green_o, out_blue_o, lit_o, flashing_o});
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
  endtask

  task automatic write_level(logic [CFG_IDX_W-1:0] idx, logic [LEVEL_W-1:0] level);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'($urandom);
    data[LEVEL_W-1:0] = level;
    write_reg(idx, data);
  endtask

  task automatic apply_setting(logic [LEVEL_W-1:0] red, logic [LEVEL_W-1:0] green,
                               logic [LEVEL_W-1:0] blue, logic [LEVEL_W-1:0] bright,
                               logic [LEVEL_W-1:0] duty, logic [PERIOD_W-1:0] period);
    write_level(IDX_RED, red);
    write_level(IDX_GREEN, green);
    write_level(IDX_BLUE, blue);
    write_level(IDX_BRIGHT, bright);
    write_level(IDX_DUTY, duty);
    write_reg(IDX_PERIOD, period);
    if ($urandom_range(0, 1) == 1)
      write_reg($urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO, CFG_DATA_W'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_setting();
    logic [LEVEL_W-1:0]  bright;
    logic [LEVEL_W-1:0]  duty;
    logic [PERIOD_W-1:0] period;
    case ($urandom_range(0, 9))
      0:       bright = 8'd0;
      1:       bright = 8'd255;
      default: bright = LEVEL_W'($urandom_range(1, 254));
    endcase
    case ($urandom_range(0, 9))
      0:       duty = DUTY_OFF;
      1:       duty = DUTY_SOLID;
      2:       duty = 8'd1;
      3:       duty = 8'd254;
      default: duty = LEVEL_W'($urandom_range(1, 254));
    endcase
    case ($urandom_range(0, 9))
      0:       period = PERIOD_W'($urandom_range(0, 49));
      1:       period = PERIOD_W'($urandom_range(300, 2000));
      2:       period = PERIOD_W'($urandom_range(9000, 16383));
      default: period = PERIOD_W'($urandom_range(50, 300));
    endcase
    apply_setting(LEVEL_W'($urandom_range(0, 255)), LEVEL_W'($urandom_range(0, 255)),
                  LEVEL_W'($urandom_range(0, 255)), bright, duty, period);
  endtask

  task automatic drive_tick(logic req, logic [FLASH_W-1:0] fms, int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    flash_request_i <= req;
    flash_ms_i      <= fms;
    do @(posedge clk_i); while (in_stall_o);
    tracker.note_tick(req, fms);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [FLASH_W-1:0] pick_flash_ms();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 7) return FLASH_W'($urandom_range(0, 30));
    if (r < 9) return FLASH_W'($urandom_range(0, 300));
    return FLASH_W'($urandom);
  endfunction

  initial begin : stimulus
    logic        req;
    int unsigned gap;
    tracker = new();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    apply_setting(8'd255, 8'd0, 8'd128, 8'd255, 8'd128, 14'd100);
    drive_tick(1'b0, 16'h0000, 0);
    drive_tick(1'b0, 16'hFFFF, 0);
    drive_tick(1'b1, 16'h0000, 0);
    drive_tick(1'b0, 16'h0000, 0);
    drive_tick(1'b1, 16'h0001, 0);
    drive_tick(1'b0, 16'h0000, 0);
    drive_tick(1'b1, 16'h0003, 0);
    repeat (3) drive_tick(1'b0, 16'h0000, 0);
    drive_tick(1'b1, 16'hFFFF, 0);
    repeat (2) drive_tick(1'b0, 16'hAAAA, 0);
    drive_tick(1'b1, 16'h0002, 0);
    drive_tick(1'b1, 16'h0000, 0);
    repeat (2) drive_tick(1'b0, 16'h5555, 1);

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0:       apply_setting(8'd200, 8'd100, 8'd50, 8'd128, 8'd254, 14'd10000);
        1:       apply_setting(8'd255, 8'd255, 8'd255, 8'd1, 8'd254, 14'd50);
        2:       apply_setting(8'd255, 8'd255, 8'd255, 8'd255, DUTY_SOLID, 14'd16383);
        3:       apply_setting(8'd1, 8'd2, 8'd3, 8'd0, 8'd1, 14'd0);
        4:       apply_setting(8'd77, 8'd88, 8'd99, 8'd200, DUTY_OFF, 14'd60);
        default: random_setting();
      endcase
      sink_quiet = (p % 4 == 3);
      if (p == HOLD_PHASE) hold_req_cnt++;
      for (int unsigned i = 0; i < PHASE_TICKS; i++) begin
        req = ($urandom_range(0, 99) < 6);
        gap = (sink_quiet || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
        drive_tick(req, pick_flash_ms(), gap);
      end
    end
    settle();

    if (tracker.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
